FILE: rtl/core/ces_pkg.sv
// ----------------------------------------------------------------------------
// ces_pkg
// Types and constants shared by the capture exposure stepper modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ces_pkg;

	// Luma bounds for a bright day and for an overcast day or dusk.
	localparam logic [7:0] DAY_LUMA_LOW  = 8'd120;
	localparam logic [7:0] DAY_LUMA_HIGH = 8'd180;
	localparam logic [7:0] DIM_LUMA_LOW  = 8'd90;
	localparam logic [7:0] DIM_LUMA_HIGH = 8'd140;

	// Step sizes of one daytime adjustment.
	localparam logic [7:0]  GAIN_STEP    = 8'd10;
	localparam logic [15:0] SHUTTER_STEP = 16'd100;

	// Scene classes.
	localparam logic [1:0] ENV_BRIGHT = 2'd0;
	localparam logic [1:0] ENV_DIM    = 2'd1;

	// Values after reset.
	localparam logic [15:0] CUR_SHUTTER_RST     = 16'd300;
	localparam logic [7:0]  CUR_GAIN_RST        = 8'd60;
	localparam logic [7:0]  GAIN_CEILING_RST    = 8'd120;
	localparam logic [15:0] SHUTTER_CEILING_RST = 16'd3800;
	localparam logic [7:0]  GAIN_FLOOR_RST      = 8'd10;
	localparam logic [15:0] SHUTTER_FLOOR_RST   = 16'd200;
	localparam logic [15:0] MANUAL_SHUTTER_RST  = 16'd1500;
	localparam logic [7:0]  MANUAL_GAIN_RST     = 8'd60;

	// Configuration register indexes.
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 16;
	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_AUTO_ENABLE     = 3'd0,
		CFG_GAIN_CEILING    = 3'd1,
		CFG_SHUTTER_CEILING = 3'd2,
		CFG_GAIN_FLOOR      = 3'd3,
		CFG_SHUTTER_FLOOR   = 3'd4,
		CFG_MANUAL_SHUTTER  = 3'd5,
		CFG_MANUAL_GAIN     = 3'd6
	} cfg_idx_t;

	// Limits and manual values used by the back end.
	typedef struct packed {
		logic [7:0]  gain_ceiling;
		logic [15:0] shutter_ceiling;
		logic [7:0]  gain_floor;
		logic [15:0] shutter_floor;
		logic [15:0] manual_shutter;
		logic [7:0]  manual_gain;
	} limits_t;

	// Classified operation of one input word.
	typedef enum logic [2:0] {
		OP_ACK   = 3'd0,
		OP_HOLD  = 3'd1,
		OP_SCENE = 3'd2,
		OP_DAY   = 3'd3,
		OP_NIGHT = 3'd4
	} op_t;

	// Command word passed from the front end to the back end.
	typedef struct packed {
		op_t        op;
		logic       dim;
		logic [7:0] luma;
	} cmd_t;

	// Result word.
	typedef struct packed {
		logic [15:0] shutter;
		logic [7:0]  gain;
		logic        apply;
	} res_t;

endpackage

`default_nettype wire

FILE: rtl/core/ces_fifo.sv
// ----------------------------------------------------------------------------
// ces_fifo
// Small synchronous queue with registered storage and an occupancy count.
// ----------------------------------------------------------------------------
`default_nettype none

module ces_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = store_q[rd_ptr_q];

	// Storage is written at the write pointer and needs no reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers wrap at the depth; the count tracks occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/ces_front.sv
// ----------------------------------------------------------------------------
// ces_front
// Accepts input words and classifies each into a command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ces_front (
	input  wire logic         push,
	input  wire logic         queue_full,
	input  wire logic         auto_enable,
	input  wire logic         func,
	input  wire logic [7:0]   avg_luma,
	input  wire logic [1:0]   env_class,
	input  wire logic         scene_changed,
	output logic              cmd_push,
	output ces_pkg::cmd_t     cmd
);

	assign cmd_push = push && !queue_full;

	// Decide the operation; a scene change outranks the scene class.
	always_comb begin
		cmd.luma = avg_luma;
		cmd.dim  = (env_class == ces_pkg::ENV_DIM);
		if (func) begin
			cmd.op = ces_pkg::OP_ACK;
		end else if (!auto_enable) begin
			cmd.op = ces_pkg::OP_HOLD;
		end else if (scene_changed) begin
			cmd.op = ces_pkg::OP_SCENE;
		end else if (env_class inside {ces_pkg::ENV_BRIGHT, ces_pkg::ENV_DIM}) begin
			cmd.op = ces_pkg::OP_DAY;
		end else begin
			cmd.op = ces_pkg::OP_NIGHT;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/ces_back.sv
// ----------------------------------------------------------------------------
// ces_back
// Carries out classified commands: holds shutter, gain, the pair accumulator
// and the pending flag, and forms one result word per command.
// ----------------------------------------------------------------------------
`default_nettype none

module ces_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire ces_pkg::limits_t lim,
	input  wire logic            cmd_valid,
	input  wire ces_pkg::cmd_t   cmd,
	input  wire logic            res_full,
	output logic                 cmd_pop,
	output logic                 res_push,
	output ces_pkg::res_t        res
);

	logic [15:0] shutter_q;
	logic [7:0]  gain_q;
	logic        pair_q;
	logic [7:0]  lsum_q;
	logic        pend_q;

	logic [15:0] shutter_d;
	logic [7:0]  gain_d;
	logic        pair_d;
	logic [7:0]  lsum_d;
	logic        pend_d;
	logic        fresh;

	logic [8:0]  pair_sum;
	logic [7:0]  pair_avg;
	logic [7:0]  lo_bound;
	logic [7:0]  hi_bound;
	logic [8:0]  gain_inc;
	logic [8:0]  gain_lim;
	logic [16:0] shutter_inc;
	logic [16:0] shutter_lim;
	logic [7:0]  gain_up;
	logic [7:0]  gain_dn;
	logic [15:0] shutter_up;
	logic [15:0] shutter_dn;
	logic [7:0]  gain_step;
	logic [15:0] shutter_new;
	logic        differs;

	assign cmd_pop  = cmd_valid && !res_full;
	assign res_push = cmd_pop;

	// Pair average and the bounds of the scene class.
	assign pair_sum = {1'b0, lsum_q} + {1'b0, cmd.luma};
	assign pair_avg = pair_sum[8:1];
	assign lo_bound = cmd.dim ? ces_pkg::DIM_LUMA_LOW : ces_pkg::DAY_LUMA_LOW;
	assign hi_bound = cmd.dim ? ces_pkg::DIM_LUMA_HIGH : ces_pkg::DAY_LUMA_HIGH;

	// One step up, limited to the ceiling.
	assign gain_inc    = {1'b0, gain_q} + {1'b0, ces_pkg::GAIN_STEP};
	assign shutter_inc = {1'b0, shutter_q} + {1'b0, ces_pkg::SHUTTER_STEP};
	assign gain_up     = (gain_q < lim.gain_ceiling && gain_inc <= {1'b0, lim.gain_ceiling})
		? gain_inc[7:0] : lim.gain_ceiling;
	assign shutter_up  = (shutter_q < lim.shutter_ceiling
		&& shutter_inc <= {1'b0, lim.shutter_ceiling})
		? shutter_inc[15:0] : lim.shutter_ceiling;

	// One step down, limited to the floor.
	assign gain_lim    = {1'b0, lim.gain_floor} + {1'b0, ces_pkg::GAIN_STEP};
	assign shutter_lim = {1'b0, lim.shutter_floor} + {1'b0, ces_pkg::SHUTTER_STEP};
	assign gain_dn     = ({1'b0, gain_q} >= gain_lim)
		? gain_q - ces_pkg::GAIN_STEP : lim.gain_floor;
	assign shutter_dn  = ({1'b0, shutter_q} >= shutter_lim)
		? shutter_q - ces_pkg::SHUTTER_STEP : lim.shutter_floor;

	// Outcome of a completed pair.
	always_comb begin
		if (pair_avg < lo_bound) begin
			gain_step   = gain_up;
			shutter_new = shutter_up;
		end else if (pair_avg > hi_bound) begin
			gain_step   = gain_dn;
			shutter_new = shutter_dn;
		end else begin
			gain_step   = gain_q;
			shutter_new = shutter_q;
		end
	end

	assign differs = (shutter_q != lim.manual_shutter) || (gain_q != lim.manual_gain);

	// Next state for the command at the head of the queue.
	always_comb begin
		shutter_d = shutter_q;
		gain_d    = gain_q;
		pair_d    = pair_q;
		lsum_d    = lsum_q;
		pend_d    = pend_q;
		fresh     = 1'b0;
		case (cmd.op)
			ces_pkg::OP_ACK: begin
				pend_d = 1'b0;
			end
			ces_pkg::OP_SCENE: begin
				if (!pend_q) begin
					shutter_d = lim.manual_shutter;
					gain_d    = lim.manual_gain;
					pend_d    = 1'b1;
					fresh     = 1'b1;
				end
			end
			ces_pkg::OP_DAY: begin
				if (!pend_q) begin
					if (!pair_q) begin
						pair_d = 1'b1;
						lsum_d = cmd.luma;
					end else begin
						shutter_d = shutter_new;
						gain_d    = gain_step;
						pair_d    = 1'b0;
						lsum_d    = '0;
						fresh     = (shutter_new != shutter_q) || (gain_step != gain_q);
						pend_d    = fresh;
					end
				end
			end
			ces_pkg::OP_NIGHT: begin
				if (!pend_q && differs) begin
					shutter_d = lim.manual_shutter;
					gain_d    = lim.manual_gain;
					pend_d    = 1'b1;
					fresh     = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign res.shutter = shutter_d;
	assign res.gain    = gain_d;
	assign res.apply   = fresh;

	// State advances once per executed command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shutter_q <= ces_pkg::CUR_SHUTTER_RST;
			gain_q    <= ces_pkg::CUR_GAIN_RST;
			pair_q    <= 1'b0;
			lsum_q    <= '0;
			pend_q    <= 1'b0;
		end else if (cmd_pop) begin
			shutter_q <= shutter_d;
			gain_q    <= gain_d;
			pair_q    <= pair_d;
			lsum_q    <= lsum_d;
			pend_q    <= pend_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/capture_exposure_stepper_core.sv
// ----------------------------------------------------------------------------
// capture_exposure_stepper_core
// Steps capture shutter and gain from pairs of frame luma measurements, with
// manual reload at night or on scene change and an acknowledge handshake.
//
//   Channel   Direction  Handshake          Words
//   input     in         push / full        func, avg_luma, env_class,
//                                            scene_changed
//   result    out        empty / pop        shutter_out, gain_out, apply_request
//   config    in         cfg_wr_en          cfg_addr, cfg_wdata
//
// One word is accepted and one result produced per cycle when neither side
// stalls. A word is classified on entry into the command queue, executed by
// the back end at the queue head and registered in the result queue, which
// feeds the result ports. Reset clears the queues and loads the reset values
// of exposure state and configuration registers. The queues let either side
// stall on its own; full rises only when CMD_DEPTH commands are queued.
// ----------------------------------------------------------------------------
`default_nettype none

module capture_exposure_stepper_core #(
	parameter int CMD_DEPTH = 2,
	parameter int RES_DEPTH = 2
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [ces_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  wire logic [ces_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  wire logic                            push,
	output logic                                 full,
	input  wire logic                            func,
	input  wire logic [7:0]                      avg_luma,
	input  wire logic [1:0]                      env_class,
	input  wire logic                            scene_changed,
	output logic                                 empty,
	input  wire logic                            pop,
	output logic [15:0]                          shutter_out,
	output logic [7:0]                           gain_out,
	output logic                                 apply_request
);

	logic             auto_enable_q;
	ces_pkg::limits_t lim_q;

	logic             cmd_push;
	ces_pkg::cmd_t    cmd_in;
	ces_pkg::cmd_t    cmd_head;
	logic             cmd_empty;
	logic             cmd_pop;
	logic             res_push;
	logic             res_full;
	ces_pkg::res_t    res_in;
	ces_pkg::res_t    res_head;

	// Configuration registers, written by index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_enable_q         <= 1'b0;
			lim_q.gain_ceiling    <= ces_pkg::GAIN_CEILING_RST;
			lim_q.shutter_ceiling <= ces_pkg::SHUTTER_CEILING_RST;
			lim_q.gain_floor      <= ces_pkg::GAIN_FLOOR_RST;
			lim_q.shutter_floor   <= ces_pkg::SHUTTER_FLOOR_RST;
			lim_q.manual_shutter  <= ces_pkg::MANUAL_SHUTTER_RST;
			lim_q.manual_gain     <= ces_pkg::MANUAL_GAIN_RST;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				ces_pkg::CFG_AUTO_ENABLE:     auto_enable_q         <= cfg_wdata[0];
				ces_pkg::CFG_GAIN_CEILING:    lim_q.gain_ceiling    <= cfg_wdata[7:0];
				ces_pkg::CFG_SHUTTER_CEILING: lim_q.shutter_ceiling <= cfg_wdata;
				ces_pkg::CFG_GAIN_FLOOR:      lim_q.gain_floor      <= cfg_wdata[7:0];
				ces_pkg::CFG_SHUTTER_FLOOR:   lim_q.shutter_floor   <= cfg_wdata;
				ces_pkg::CFG_MANUAL_SHUTTER:  lim_q.manual_shutter  <= cfg_wdata;
				ces_pkg::CFG_MANUAL_GAIN:     lim_q.manual_gain     <= cfg_wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	// Front end: classification of incoming words.
	ces_front u_front (
		.push          (push),
		.queue_full    (full),
		.auto_enable   (auto_enable_q),
		.func          (func),
		.avg_luma      (avg_luma),
		.env_class     (env_class),
		.scene_changed (scene_changed),
		.cmd_push      (cmd_push),
		.cmd           (cmd_in)
	);

	// Command queue between front and back.
	ces_fifo #(
		.WIDTH ($bits(ces_pkg::cmd_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (full),
		.pop    (cmd_pop),
		.rdata  (cmd_head),
		.empty  (cmd_empty)
	);

	// Back end: exposure state and stepping.
	ces_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.lim       (lim_q),
		.cmd_valid (!cmd_empty),
		.cmd       (cmd_head),
		.res_full  (res_full),
		.cmd_pop   (cmd_pop),
		.res_push  (res_push),
		.res       (res_in)
	);

	// Result queue towards the consumer.
	ces_fifo #(
		.WIDTH ($bits(ces_pkg::res_t)),
		.DEPTH (RES_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_head),
		.empty  (empty)
	);

	assign shutter_out   = res_head.shutter;
	assign gain_out      = res_head.gain;
	assign apply_request = res_head.apply;

endmodule

`default_nettype wire
